FILE: hw/rtl/jaes_pkg.sv
// Shared types, character codes and byte classifiers for the JSON array element splitter.
`timescale 1ns / 1ps

package jaes_pkg;

  localparam int OFFSET_BITS_DEF = 16;
  localparam int OUT_BITS = 16;
  localparam logic [OUT_BITS-1:0] OUT_MAX = 16'hFFFF;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_UNTERM  = 2'd1;
  localparam logic [1:0] ERR_STRAY   = 2'd2;

  typedef enum logic [2:0] {
    PH_SEP,
    PH_ELEM,
    PH_SCALAR,
    PH_STRING,
    PH_CONTAINER
  } phase_t;

  typedef struct packed {
    logic                element_done;
    logic [OUT_BITS-1:0] element_start;
    logic [OUT_BITS-1:0] element_end;
    logic [OUT_BITS-1:0] element_count;
    logic                array_done;
    logic [1:0]          error_code;
  } result_t;

  function automatic logic is_gap_space(input logic [7:0] b);
    is_gap_space = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
  endfunction

  function automatic logic ends_scalar(input logic [7:0] b);
    ends_scalar = is_gap_space(b) || (b == CH_NUL) || (b == CH_COMMA) ||
                  (b == CH_RBRACK) || (b == CH_RBRACE) || (b == CH_VT) || (b == CH_FF);
  endfunction

endpackage

FILE: hw/rtl/jaes_scan.sv
// Scan state and the one-byte step logic that produces a result word.
`timescale 1ns / 1ps

module jaes_scan #(
  parameter int OFFSET_BITS = jaes_pkg::OFFSET_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        text_byte,
  input  logic              first_byte,
  output jaes_pkg::result_t result
);
  import jaes_pkg::*;

  localparam int WIDE = (OFFSET_BITS > OUT_BITS) ? OFFSET_BITS : OUT_BITS + 1;

  function automatic logic [OFFSET_BITS-1:0] off_next(input logic [OFFSET_BITS-1:0] v);
    off_next = (v == {OFFSET_BITS{1'b1}}) ? v : OFFSET_BITS'(v + 1'b1);
  endfunction

  function automatic logic [OUT_BITS-1:0] out16(input logic [OFFSET_BITS-1:0] v);
    logic [WIDE-1:0] w;
    w = WIDE'(v);
    out16 = (w > WIDE'(OUT_MAX)) ? OUT_MAX : w[OUT_BITS-1:0];
  endfunction

  phase_t                 phase, phase_next, eff_phase, gap_phase;
  logic [15:0]            nest_depth, nest_depth_next, eff_depth, depth_dec;
  logic                   open_is_brace, open_is_brace_next, eff_brace;
  logic                   inside_quotes, inside_quotes_next, eff_inside;
  logic                   after_backslash, after_backslash_next, eff_bs;
  logic [OFFSET_BITS-1:0] byte_offset, byte_offset_next, eff_offset;
  logic [OFFSET_BITS-1:0] current_start, current_start_next, eff_start;
  logic [15:0]            elements_seen, elements_seen_next, eff_count;
  logic                   finished, finished_next, eff_finished;
  logic [1:0]             error_held, error_held_next, eff_error;
  logic                   emit, emit_at_off, emit_past, run_gap;
  logic [7:0]             open_ch, close_ch;

  always_comb begin
    if (first_byte) begin
      eff_phase    = PH_SEP;
      eff_depth    = '0;
      eff_brace    = 1'b0;
      eff_inside   = 1'b0;
      eff_bs       = 1'b0;
      eff_offset   = '0;
      eff_start    = '0;
      eff_count    = '0;
      eff_finished = 1'b0;
      eff_error    = ERR_NONE;
    end else begin
      eff_phase    = phase;
      eff_depth    = nest_depth;
      eff_brace    = open_is_brace;
      eff_inside   = inside_quotes;
      eff_bs       = after_backslash;
      eff_offset   = byte_offset;
      eff_start    = current_start;
      eff_count    = elements_seen;
      eff_finished = finished;
      eff_error    = error_held;
    end
  end

  assign open_ch   = eff_brace ? CH_LBRACE : CH_LBRACK;
  assign close_ch  = eff_brace ? CH_RBRACE : CH_RBRACK;
  assign depth_dec = (eff_depth != 16'd0) ? eff_depth - 16'd1 : 16'd0;

  // Next state for one byte.
  always_comb begin
    phase_next           = eff_phase;
    nest_depth_next      = eff_depth;
    open_is_brace_next   = eff_brace;
    inside_quotes_next   = eff_inside;
    after_backslash_next = eff_bs;
    current_start_next   = eff_start;
    finished_next        = eff_finished;
    error_held_next      = eff_error;
    byte_offset_next     = off_next(eff_offset);
    emit                 = 1'b0;
    emit_at_off          = 1'b0;
    emit_past            = 1'b0;
    run_gap              = 1'b0;
    gap_phase            = PH_SEP;

    if (!eff_finished) begin
      case (eff_phase)
        PH_SCALAR: begin
          if (ends_scalar(text_byte)) begin
            emit       = 1'b1;
            phase_next = PH_SEP;
            run_gap    = 1'b1;
          end
        end
        PH_STRING: begin
          if (text_byte == CH_NUL) begin
            emit            = 1'b1;
            finished_next   = 1'b1;
            error_held_next = ERR_NONE;
          end else if (eff_bs) begin
            after_backslash_next = 1'b0;
          end else if (text_byte == CH_BSLASH) begin
            after_backslash_next = 1'b1;
          end else if (text_byte == CH_QUOTE) begin
            inside_quotes_next = 1'b0;
            emit               = 1'b1;
            emit_past          = 1'b1;
            phase_next         = PH_SEP;
          end
        end
        PH_CONTAINER: begin
          if (text_byte == CH_NUL) begin
            finished_next   = 1'b1;
            error_held_next = ERR_UNTERM;
          end else if (eff_inside) begin
            if (eff_bs) begin
              after_backslash_next = 1'b0;
            end else if (text_byte == CH_BSLASH) begin
              after_backslash_next = 1'b1;
            end else if (text_byte == CH_QUOTE) begin
              inside_quotes_next = 1'b0;
            end
          end else if (text_byte == CH_QUOTE) begin
            inside_quotes_next   = 1'b1;
            after_backslash_next = 1'b0;
          end else if (text_byte == open_ch) begin
            if (eff_depth != 16'hFFFF) begin
              nest_depth_next = eff_depth + 16'd1;
            end
          end else if (text_byte == close_ch) begin
            nest_depth_next = depth_dec;
            if (depth_dec == 16'd0) begin
              emit       = 1'b1;
              emit_past  = 1'b1;
              phase_next = PH_SEP;
            end
          end
        end
        PH_SEP, PH_ELEM: begin
          run_gap   = 1'b1;
          gap_phase = eff_phase;
        end
        default: begin
          phase_next = PH_SEP;
          run_gap    = 1'b1;
        end
      endcase

      if (run_gap) begin
        if (is_gap_space(text_byte)) begin
          phase_next = phase_next;
        end else if (text_byte == CH_NUL || text_byte == CH_RBRACK) begin
          finished_next   = 1'b1;
          error_held_next = ERR_NONE;
        end else if (text_byte == CH_RBRACE || text_byte == CH_VT || text_byte == CH_FF) begin
          finished_next   = 1'b1;
          error_held_next = ERR_STRAY;
        end else if (text_byte == CH_QUOTE) begin
          current_start_next   = eff_offset;
          inside_quotes_next   = 1'b1;
          after_backslash_next = 1'b0;
          phase_next           = PH_STRING;
        end else if (text_byte == CH_COMMA) begin
          if (gap_phase == PH_SEP) begin
            phase_next = PH_ELEM;
          end else begin
            emit        = 1'b1;
            emit_at_off = 1'b1;
          end
        end else if (text_byte == CH_LBRACK && gap_phase == PH_SEP) begin
          phase_next = PH_ELEM;
        end else if (text_byte == CH_LBRACK || text_byte == CH_LBRACE) begin
          current_start_next   = eff_offset;
          nest_depth_next      = 16'd1;
          open_is_brace_next   = (text_byte == CH_LBRACE);
          inside_quotes_next   = 1'b0;
          after_backslash_next = 1'b0;
          phase_next           = PH_CONTAINER;
        end else begin
          current_start_next = eff_offset;
          phase_next         = PH_SCALAR;
        end
      end
    end

    elements_seen_next = (emit && eff_count != 16'hFFFF) ? eff_count + 16'd1 : eff_count;
  end

  // Result word for the byte.
  always_comb begin
    result.element_done  = emit;
    result.element_start = '0;
    result.element_end   = '0;
    if (emit) begin
      result.element_start = out16(emit_at_off ? eff_offset : eff_start);
      result.element_end   = out16(emit_past ? byte_offset_next : eff_offset);
    end
    result.element_count = elements_seen_next;
    result.array_done    = finished_next;
    result.error_code    = error_held_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_SEP;
      nest_depth      <= '0;
      open_is_brace   <= 1'b0;
      inside_quotes   <= 1'b0;
      after_backslash <= 1'b0;
      byte_offset     <= '0;
      current_start   <= '0;
      elements_seen   <= '0;
      finished        <= 1'b0;
      error_held      <= ERR_NONE;
    end else if (step) begin
      phase           <= phase_next;
      nest_depth      <= nest_depth_next;
      open_is_brace   <= open_is_brace_next;
      inside_quotes   <= inside_quotes_next;
      after_backslash <= after_backslash_next;
      byte_offset     <= byte_offset_next;
      current_start   <= current_start_next;
      elements_seen   <= elements_seen_next;
      finished        <= finished_next;
      error_held      <= error_held_next;
    end
  end

`ifndef SYNTHESIS
  a_error_only_when_finished: assert property (@(posedge clk) disable iff (rst)
    !finished |-> error_held == ERR_NONE)
    else $error("Error code held while the scan is still running.");

  a_container_has_depth: assert property (@(posedge clk) disable iff (rst)
    phase == PH_CONTAINER |-> nest_depth != 16'd0)
    else $error("Container phase with zero nesting depth.");

  a_quotes_in_string_or_container: assert property (@(posedge clk) disable iff (rst)
    inside_quotes |-> (phase == PH_STRING || phase == PH_CONTAINER))
    else $error("Quote mark set outside a string or container.");

  a_count_steps_by_one: assert property (@(posedge clk) disable iff (rst)
    step && !first_byte |=> (elements_seen - $past(elements_seen)) <= 16'd1)
    else $error("Element count advanced by more than one word.");

  a_end_not_before_start: assert property (@(posedge clk) disable iff (rst)
    step && result.element_done |-> result.element_end >= result.element_start)
    else $error("Element end offset lies before its start offset.");
`endif

endmodule

FILE: hw/rtl/json_array_element_splitter_core.sv
// Top level of the JSON array element splitter: input stage, scan logic and result register.
`timescale 1ns / 1ps

// Channel  Direction  Word contents
// s_axis   in         tdata: text_byte; tuser: first_byte
// m_axis   out        tdata: element_start, element_end, element_count, array_done,
//                     error_code; tuser: element_done
//
// One byte is taken per clock while m_axis is not stalled, and each byte gives exactly one result word.
// A byte is held in the input register until the scan step can take it; the step then
// writes its result word into the result register, which drives m_axis.
// The scan state loop feeds the registered scan state back through the step logic.
// Reset clears the scan state and both stage valid flags.
// A stall on m_axis holds the result and then the input word in place.

module json_array_element_splitter_core #(
  parameter int OFFSET_BITS = jaes_pkg::OFFSET_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] text_byte
  input  logic        s_axis_tuser,  // [0] first_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // [15:0] element_start, [31:16] element_end,
                                     // [47:32] element_count, [48] array_done,
                                     // [50:49] error_code, [55:51] zero
  output logic        m_axis_tuser   // [0] element_done
);
  import jaes_pkg::*;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_first;
  logic       out_open;
  logic       advance;
  result_t    step_result;
  result_t    out_word;

  assign out_open      = !m_axis_tvalid || m_axis_tready;
  assign advance       = in_valid && out_open;
  assign s_axis_tready = !in_valid || out_open;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte  <= s_axis_tdata;
      in_first <= s_axis_tuser;
    end
  end

  jaes_scan #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .text_byte (in_byte),
    .first_byte(in_first),
    .result    (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word <= step_result;
    end
  end

  assign m_axis_tdata = {5'b00000, out_word.error_code, out_word.array_done,
                         out_word.element_count, out_word.element_end,
                         out_word.element_start};
  assign m_axis_tuser = out_word.element_done;

endmodule
